[hw/rtl/rsr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsr_pkg
// Shared types and constants of the record substring router.
// ----------------------------------------------------------------------------
package rsr_pkg;

  localparam int NEEDLE_BYTES = 16;
  localparam int LEN_W        = 5;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LEN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT      = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       record_end;
  } req_t;

  typedef struct packed {
    logic route_secondary;
    logic needle_found;
  } res_t;

  // needle as seen by the search: bytes, usable length, invert flag
  typedef struct packed {
    logic [NEEDLE_BYTES-1:0][7:0] needle;
    logic [LEN_W-1:0]             eff_len;
    logic                         invert;
  } cfg_t;

endpackage

[hw/rtl/rsr_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsr_cfg
// Configuration registers and the usable needle length.
// ----------------------------------------------------------------------------
module rsr_cfg #(
  parameter int MAX_NEEDLE = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rsr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output rsr_pkg::cfg_t                    cfg
);

  logic [63:0]               needle_low;
  logic [63:0]               needle_high;
  logic [rsr_pkg::LEN_W-1:0] needle_length;
  logic                      invert_mode;
  logic [rsr_pkg::LEN_W-1:0] clamp_len;
  logic [rsr_pkg::LEN_W-1:0] eff_len;
  logic [rsr_pkg::NEEDLE_BYTES-1:0][7:0] needle;

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_low    <= '0;
      needle_high   <= '0;
      needle_length <= '0;
      invert_mode   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rsr_pkg::REG_NEEDLE_LOW:  needle_low    <= cfg_data;
        rsr_pkg::REG_NEEDLE_HIGH: needle_high   <= cfg_data;
        rsr_pkg::REG_NEEDLE_LEN:  needle_length <= cfg_data[rsr_pkg::LEN_W-1:0];
        rsr_pkg::REG_INVERT:      invert_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign needle = {needle_high, needle_low};

  // length clamped to MAX_NEEDLE, then cut at the first zero byte
  always_comb begin
    clamp_len = (needle_length > rsr_pkg::LEN_W'(MAX_NEEDLE)) ?
                rsr_pkg::LEN_W'(MAX_NEEDLE) : needle_length;
    eff_len = clamp_len;
    for (int i = rsr_pkg::NEEDLE_BYTES - 1; i >= 0; i--) begin
      if ((rsr_pkg::LEN_W'(i) < clamp_len) && (needle[i] == 8'h00)) begin
        eff_len = rsr_pkg::LEN_W'(i);
      end
    end
  end

  assign cfg.needle  = needle;
  assign cfg.eff_len = eff_len;
  assign cfg.invert  = invert_mode;

endmodule

[hw/rtl/rsr_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsr_search
// Per-record search state: byte window, fill, found flag, terminator, count.
// ----------------------------------------------------------------------------
module rsr_search #(
  parameter int MAX_NEEDLE   = 16,
  parameter int RECORD_LIMIT = 4095
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  rsr_pkg::req_t req,
  input  rsr_pkg::cfg_t cfg,
  output logic          found
);

  localparam int WIN_D  = (MAX_NEEDLE > 1) ? MAX_NEEDLE - 1 : 1;
  localparam int FILL_W = $clog2(MAX_NEEDLE + 1);
  localparam int CNT_W  = $clog2(RECORD_LIMIT + 1);

  logic [WIN_D-1:0][7:0] window;
  logic [FILL_W-1:0]     fill;
  logic                  match_seen;
  logic                  terminator_seen;
  logic [CNT_W-1:0]      byte_count;

  logic                  take;
  logic                  search;
  logic [MAX_NEEDLE:1]   cand;
  logic                  hit;

  assign take   = step && req.byte_present && !terminator_seen &&
                  (byte_count < CNT_W'(RECORD_LIMIT));
  assign search = take && (req.data_byte != 8'h00);

  // one candidate per needle length, picked by the usable length
  always_comb begin
    logic ok;
    cand = '0;
    for (int l = 1; l <= MAX_NEEDLE; l++) begin
      ok = (cfg.needle[l-1] == req.data_byte) && (fill >= FILL_W'(l - 1));
      for (int k = 1; k < l; k++) begin
        if (window[k-1] != cfg.needle[l-1-k]) begin
          ok = 1'b0;
        end
      end
      cand[l] = ok;
    end
    hit = 1'b0;
    for (int l = 1; l <= MAX_NEEDLE; l++) begin
      if (cfg.eff_len == rsr_pkg::LEN_W'(l)) begin
        hit = cand[l];
      end
    end
  end

  assign found = match_seen || (search && hit) || (cfg.eff_len == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill            <= '0;
      match_seen      <= 1'b0;
      terminator_seen <= 1'b0;
      byte_count      <= '0;
    end else if (step && req.record_end) begin
      fill            <= '0;
      match_seen      <= 1'b0;
      terminator_seen <= 1'b0;
      byte_count      <= '0;
    end else if (take) begin
      byte_count <= byte_count + 1'b1;
      if (!search) begin
        terminator_seen <= 1'b1;
      end else begin
        if (hit) begin
          match_seen <= 1'b1;
        end
        if (fill < FILL_W'(MAX_NEEDLE - 1)) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  // window bytes beyond fill are never compared, so no clear
  always_ff @(posedge clk) begin
    if (search) begin
      window[0] <= req.data_byte;
      for (int i = 1; i < WIN_D; i++) begin
        window[i] <= window[i-1];
      end
    end
  end

endmodule

[hw/rtl/record_substring_router_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_substring_router_core
// Streams record bytes, flags records that contain the needle and routes them.
// ----------------------------------------------------------------------------
//  channel  signals                       payload
//  req      req_valid / req_ready         data_byte, byte_present, record_end
//  res      res_valid / res_ready         route_secondary, needle_found
//  cfg      cfg_we, cfg_index, cfg_data   needle low/high, length, invert
//
//  one request per cycle, unless a held result stalls a request that ends a record
//  path: request register, window compare, result register
//  a held result only stalls a request that ends a record; others keep flowing
//  synchronous reset clears valid flags, config and record state; window is not cleared
// ----------------------------------------------------------------------------
module record_substring_router_core #(
  parameter int MAX_NEEDLE   = 16,
  parameter int RECORD_LIMIT = 4095
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  rsr_pkg::req_t                  req,
  output logic                           res_valid,
  input  logic                           res_ready,
  output rsr_pkg::res_t                  res,
  input  logic                           cfg_we,
  input  logic [rsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsr_pkg::CFG_DATA_W-1:0] cfg_data
);

  rsr_pkg::cfg_t cfg;
  rsr_pkg::req_t hold;
  logic          hold_valid;
  logic          go;
  logic          found;

  rsr_cfg #(
    .MAX_NEEDLE (MAX_NEEDLE)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign go        = hold_valid && (!hold.record_end || !res_valid || res_ready);
  assign req_ready = !hold_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_ready) begin
      hold_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      hold <= req;
    end
  end

  rsr_search #(
    .MAX_NEEDLE   (MAX_NEEDLE),
    .RECORD_LIMIT (RECORD_LIMIT)
  ) u_search (
    .clk   (clk),
    .rst   (rst),
    .step  (go),
    .req   (hold),
    .cfg   (cfg),
    .found (found)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (go && hold.record_end) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && hold.record_end) begin
      res.needle_found    <= found;
      res.route_secondary <= ~(found ^ cfg.invert);
    end
  end

endmodule

[sim/record_substring_router_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_substring_router_core_test
// Streams records into the router and predicts each routing result in a
// scoreboard that tracks the search window, the found flag and the needle
// setup. Directed records exercise empty needles, zero bytes, long needle
// lengths, a needle change mid-record and an over-long record. Random phases
// with fresh needles follow, under random idling on both sides and one long
// result stall.
// ----------------------------------------------------------------------------
module record_substring_router_core_test;

  localparam int BYTE_LIMIT   = 4095;
  localparam int WINDOW_DEPTH = rsr_pkg::NEEDLE_BYTES - 1;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 100;

  class route_scoreboard;
    logic [63:0]   needle_low;
    logic [63:0]   needle_high;
    logic [4:0]    needle_len;
    logic          invert;
    logic [7:0]    recent [WINDOW_DEPTH];
    int unsigned   fill;
    bit            found;
    bit            stopped;
    int unsigned   seen_bytes;
    rsr_pkg::res_t expected_routes [$];
    int unsigned   mismatches;

    function new();
      needle_low  = '0;
      needle_high = '0;
      needle_len  = '0;
      invert      = 1'b0;
      mismatches  = 0;
      clear_record();
    endfunction

    function void clear_record();
      foreach (recent[i]) recent[i] = 8'h00;
      fill       = 0;
      found      = 0;
      stopped    = 0;
      seen_bytes = 0;
    endfunction

    function void set_register(logic [rsr_pkg::CFG_IDX_W-1:0] idx,
                               logic [63:0] value);
      case (idx)
        rsr_pkg::REG_NEEDLE_LOW:  needle_low  = value;
        rsr_pkg::REG_NEEDLE_HIGH: needle_high = value;
        rsr_pkg::REG_NEEDLE_LEN:  needle_len  = value[4:0];
        rsr_pkg::REG_INVERT:      invert      = value[0];
        default: ;
      endcase
    endfunction

    function logic [7:0] needle_byte(int i);
      return (i < 8) ? needle_low[i*8 +: 8] : needle_high[(i-8)*8 +: 8];
    endfunction

    // needle stops at its first zero byte
    function int unsigned usable_length();
      int unsigned n;
      n = (needle_len > rsr_pkg::NEEDLE_BYTES) ? rsr_pkg::NEEDLE_BYTES : needle_len;
      for (int i = 0; i < n; i++) begin
        if (needle_byte(i) == 8'h00) return i;
      end
      return n;
    endfunction

    function void note_request(rsr_pkg::req_t r);
      int unsigned   n;
      bit            hit;
      rsr_pkg::res_t want;
      if (r.byte_present && !stopped && seen_bytes < BYTE_LIMIT) begin
        seen_bytes++;
        if (r.data_byte == 8'h00) begin
          stopped = 1;
        end else begin
          n = usable_length();
          if (n > 0 && fill + 1 >= n && needle_byte(n - 1) == r.data_byte) begin
            hit = 1;
            for (int k = 1; k < n; k++) begin
              if (recent[k-1] != needle_byte(n - 1 - k)) hit = 0;
            end
            if (hit) found = 1;
          end
          for (int k = WINDOW_DEPTH - 1; k > 0; k--) recent[k] = recent[k-1];
          recent[0] = r.data_byte;
          if (fill < WINDOW_DEPTH) fill++;
        end
      end
      if (r.record_end) begin
        hit = found || (usable_length() == 0);
        want.needle_found    = hit;
        want.route_secondary = ~(hit ^ invert);
        expected_routes.push_back(want);
        clear_record();
      end
    endfunction

    function void check_result(rsr_pkg::res_t got);
      rsr_pkg::res_t want;
      if (expected_routes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: secondary=%0b found=%0b",
                   got.route_secondary, got.needle_found);
        return;
      end
      want = expected_routes.pop_front();
      if (got.route_secondary !== want.route_secondary ||
          got.needle_found !== want.needle_found) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"route mismatch: expected secondary=%0b found=%0b,",
                    " got secondary=%0b found=%0b"},
                   want.route_secondary, want.needle_found,
                   got.route_secondary, got.needle_found);
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst         = 1'b1;
  logic                           req_valid   = 1'b0;
  logic                           req_ready;
  rsr_pkg::req_t                  req         = '0;
  logic                           res_valid;
  logic                           res_ready   = 1'b0;
  rsr_pkg::res_t                  res;
  logic                           cfg_we      = 1'b0;
  logic [rsr_pkg::CFG_IDX_W-1:0]  cfg_index   = rsr_pkg::REG_NEEDLE_LOW;
  logic [rsr_pkg::CFG_DATA_W-1:0] cfg_data    = '0;

  logic                           quiet_on    = 1'b0;
  logic                           pressure_on = 1'b0;
  logic                           hold_done   = 1'b0;
  int                             hold_left   = 0;
  int unsigned                    cycle_count = 0;
  logic [7:0]                     pick [rsr_pkg::NEEDLE_BYTES];

  route_scoreboard sb = new();

  record_substring_router_core #(
    .MAX_NEEDLE  (rsr_pkg::NEEDLE_BYTES),
    .RECORD_LIMIT(BYTE_LIMIT)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && res_ready) sb.check_result(res);
      if (req_valid && req_ready) sb.note_request(req);
    end
  end

  // result side: random stalls, one long hold-off in the pressure phase
  always @(posedge clk) begin
    if (hold_left > 0) begin
      res_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (pressure_on && !hold_done) begin
      res_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      res_ready <= quiet_on || ($urandom_range(99) >= 12);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic present, input logic last);
    while (!quiet_on && $urandom_range(99) < 12) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{data_byte: b, byte_present: present, record_end: last};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_routes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [rsr_pkg::CFG_IDX_W-1:0] idx,
                                input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_register(idx, value);
  endtask

  task automatic configure(input logic [4:0] len, input logic inv);
    logic [63:0] low;
    logic [63:0] high;
    for (int i = 0; i < 8; i++) begin
      low[i*8 +: 8]  = pick[i];
      high[i*8 +: 8] = pick[i+8];
    end
    write_register(rsr_pkg::REG_NEEDLE_LOW, low);
    write_register(rsr_pkg::REG_NEEDLE_HIGH, high);
    write_register(rsr_pkg::REG_NEEDLE_LEN, {59'd0, len});
    write_register(rsr_pkg::REG_INVERT, {63'd0, inv});
    cfg_we <= 1'b0;
  endtask

  // bytes past the text are junk, so the length register has to cut them off
  task automatic load_text(input string s);
    foreach (pick[i]) pick[i] = (i < s.len()) ? s[i] : 8'($urandom_range(1, 255));
  endtask

  task automatic send_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b1, last && i == s.len() - 1);
  endtask

  task automatic send_random_record(inout int sent);
    int         nbytes;
    int         embed_at;
    bit         empty_tail;
    logic [7:0] b;
    if ($urandom_range(99) < 5) nbytes = 0;
    else if ($urandom_range(99) < 10) nbytes = $urandom_range(30, 80);
    else nbytes = $urandom_range(1, 24);
    empty_tail = (nbytes == 0) || ($urandom_range(99) < 15);
    embed_at   = ($urandom_range(99) < 45) ? $urandom_range(0, nbytes) : -1;
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(99) < 4) send_item(8'($urandom), 1'b0, 1'b0);
      if (embed_at >= 0 && i >= embed_at && i - embed_at < rsr_pkg::NEEDLE_BYTES)
        b = pick[i - embed_at];
      else if ($urandom_range(99) < 50)
        b = pick[$urandom_range(0, rsr_pkg::NEEDLE_BYTES - 1)];
      else if ($urandom_range(99) < 3)
        b = 8'h00;
      else
        b = 8'($urandom);
      send_item(b, 1'b1, !empty_tail && i == nbytes - 1);
      sent++;
    end
    if (empty_tail) begin
      send_item(8'($urandom), 1'b0, 1'b1);
      sent++;
    end
  endtask

  initial begin
    int         sent;
    int         len_roll;
    logic [4:0] len;
    bit         narrow;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset setup has an empty needle: everything matches
    send_text("xy", 1'b1);
    send_item(8'($urandom), 1'b0, 1'b1);
    drain();

    load_text("abc");
    configure(5'd3, 1'b0);
    send_text("abc", 1'b1);
    send_text("xab", 1'b0);
    send_item(8'($urandom), 1'b0, 1'b0);
    send_item(8'($urandom), 1'b0, 1'b1);
    send_text("ab", 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item("c", 1'b1, 1'b1);
    drain();

    // length above the needle size, all-ones needle, inverted routing
    foreach (pick[i]) pick[i] = 8'hFF;
    configure(5'd31, 1'b1);
    for (int i = 0; i < rsr_pkg::NEEDLE_BYTES; i++)
      send_item(8'hFF, 1'b1, i == rsr_pkg::NEEDLE_BYTES - 1);
    drain();

    // zero byte inside the needle shortens it
    load_text("abc");
    pick[3] = 8'h00;
    configure(5'd8, 1'b0);
    send_text("abc", 1'b1);
    drain();

    // needle changes between two bytes of one record
    load_text("ab");
    configure(5'd2, 1'b0);
    send_item("a", 1'b1, 1'b0);
    drain();
    load_text("cb");
    configure(5'd2, 1'b1);
    send_item("b", 1'b1, 1'b1);
    drain();

    // needle lands just past the searched part of an over-long record
    load_text("q");
    configure(5'd1, 1'b0);
    for (int i = 0; i < BYTE_LIMIT; i++) send_item("r", 1'b1, 1'b0);
    send_item("q", 1'b1, 1'b1);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      narrow = ($urandom_range(1) == 1);
      foreach (pick[i])
        pick[i] = narrow ? 8'h61 + 8'($urandom_range(0, 3)) : 8'($urandom_range(1, 255));
      if ($urandom_range(99) < 10)
        pick[$urandom_range(0, rsr_pkg::NEEDLE_BYTES - 1)] = 8'h00;
      len_roll = $urandom_range(99);
      if (len_roll < 10) len = 5'd0;
      else if (len_roll < 20) len = 5'($urandom_range(17, 31));
      else if (len_roll < 60) len = 5'($urandom_range(1, 4));
      else len = 5'($urandom_range(1, 16));
      if (phase == 0) begin
        foreach (pick[i]) pick[i] = 8'hFF;
        len = 5'd16;
      end else if (phase == 1) begin
        len = 5'd31;
      end else if (phase == 2) begin
        len = 5'd0;
      end
      configure(len, 1'($urandom_range(1)));
      quiet_on    <= (phase == 3);
      pressure_on <= (phase == 6);
      sent = 0;
      while (sent < PHASE_ITEMS) send_random_record(sent);
      drain();
    end

    if (sb.mismatches == 0 && sb.expected_routes.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

[files.f]
hw/rtl/rsr_pkg.sv
hw/rtl/rsr_cfg.sv
hw/rtl/rsr_search.sv
hw/rtl/record_substring_router_core.sv
sim/record_substring_router_core_test.sv
